// File: rtl/core/depth_to_point_cloud_defines.svh
// assertion macros for the depth to point cloud block
// no dependencies; included by files that carry concurrent checks
`ifndef DEPTH_TO_POINT_CLOUD_DEFINES_SVH
`define DEPTH_TO_POINT_CLOUD_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication check
`define DTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtpc implication check failed");
// next-cycle implication check
`define DTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dtpc next-cycle check failed");
`else
`define DTPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/core/dtpc_pkg.sv
// shared types and constants for the depth to point cloud block
// no dependencies
package dtpc_pkg;

    localparam int MAX_DIM = 4096;
    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int DEC_W = 7;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_W = 34;
    localparam int DEN_W = 19;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 8'd7;

    // depth mode codes
    localparam logic MODE_DEPTH = 1'b0;
    localparam logic MODE_DISPARITY = 1'b1;

    localparam logic [31:0] MISSING_Z = 32'd10000000;

    // configuration after clamping
    typedef struct packed {
        logic [DIM_W-1:0] width_m1;
        logic [DIM_W-1:0] height_m1;
        logic [DEC_W-1:0] dec;
        logic             mode;
        logic [15:0]      cx;
        logic [15:0]      cy;
        logic [17:0]      focal;
        logic [9:0]       baseline;
    } cfg_t;

    // position of the pixel on the input port
    typedef struct packed {
        logic [DIM_W-1:0] u;
        logic [DIM_W-1:0] v;
        logic             emit;
        logic             last;
    } pix_pos_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic prep_en;
        logic div_en;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// File: rtl/core/dtpc_cfg_regs.sv
// configuration registers with clamping of out-of-range values
// depends on dtpc_pkg
module dtpc_cfg_regs
    import dtpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  cfg_wr,
    output cfg_t                  cfg
);

    logic [12:0]      width_reg;
    logic [12:0]      height_reg;
    logic [DEC_W-1:0] dec_reg;
    logic             mode_reg;
    logic [15:0]      cx_reg;
    logic [15:0]      cy_reg;
    logic [17:0]      focal_reg;
    logic [9:0]       baseline_reg;
    logic [12:0]      width_cl;
    logic [12:0]      height_cl;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 13'd1024;
            height_reg   <= 13'd544;
            dec_reg      <= 7'd32;
            mode_reg     <= MODE_DISPARITY;
            cx_reg       <= 16'd8200;
            cy_reg       <= 16'd4360;
            focal_reg    <= 18'd9697;
            baseline_reg <= 10'd70;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg <= cfg_data[12:0];
                REG_FRAME_HEIGHT: height_reg <= cfg_data[12:0];
                REG_DECIMATION:   dec_reg <= cfg_data[DEC_W-1:0];
                REG_DEPTH_MODE:   mode_reg <= cfg_data[0];
                REG_CENTER_X:     cx_reg <= cfg_data[15:0];
                REG_CENTER_Y:     cy_reg <= cfg_data[15:0];
                REG_FOCAL:        focal_reg <= cfg_data[17:0];
                REG_BASELINE:     baseline_reg <= cfg_data[9:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        width_cl = width_reg;
        if (width_reg == 13'd0)
            width_cl = 13'd1;
        else if (width_reg > 13'(MAX_DIM))
            width_cl = 13'(MAX_DIM);
        height_cl = height_reg;
        if (height_reg == 13'd0)
            height_cl = 13'd1;
        else if (height_reg > 13'(MAX_DIM))
            height_cl = 13'(MAX_DIM);
    end

    always_comb
    begin
        cfg.width_m1  = DIM_W'(width_cl - 13'd1);
        cfg.height_m1 = DIM_W'(height_cl - 13'd1);
        cfg.dec       = (dec_reg == '0) ? DEC_W'(1) : dec_reg;
        cfg.mode      = mode_reg;
        cfg.cx        = cx_reg;
        cfg.cy        = cy_reg;
        cfg.focal     = (focal_reg == '0) ? 18'd1 : focal_reg;
        cfg.baseline  = baseline_reg;
    end

endmodule

// File: rtl/core/dtpc_position.sv
// column and row tracking, sampling phases and last-point positions
// depends on dtpc_pkg; phases rebuilt by a shift-subtract remainder pass
module dtpc_position
    import dtpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     cfg_wr,
    input  logic     frame_start,
    input  logic     pix_accept,
    output pix_pos_t pos,
    output logic     busy
);

    typedef enum logic [1:0] {SYNC_LOAD, SYNC_RUN, SYNC_DONE} sync_state_t;

    localparam int SSTEP_W = $clog2(DIM_W);
    localparam int LANES = 4;

    sync_state_t          sync_state_reg;
    logic [SSTEP_W-1:0]   sync_step_reg;
    logic [DIM_W-1:0]     col_reg;
    logic [DIM_W-1:0]     row_reg;
    logic [DEC_W-1:0]     col_ph_reg;
    logic [DEC_W-1:0]     row_ph_reg;
    logic [DIM_W-1:0]     last_u_reg;
    logic [DIM_W-1:0]     last_v_reg;
    logic [DIM_W-1:0]     div_reg [0:LANES-1];
    logic [DEC_W-1:0]     rem_reg [0:LANES-1];
    logic [DEC_W-1:0]     rem_next [0:LANES-1];
    logic [DEC_W:0]       rem_shift [0:LANES-1];

    logic [DIM_W-1:0] u;
    logic [DIM_W-1:0] v;
    logic [DEC_W-1:0] u_ph;
    logic [DEC_W-1:0] v_ph;
    logic [DIM_W-1:0] col_next;
    logic [DIM_W-1:0] row_next;
    logic [DEC_W-1:0] col_ph_next;
    logic [DEC_W-1:0] row_ph_next;
    logic             sync_last;

    // one remainder bit per lane and cycle
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rem_shift[k] = {rem_reg[k], div_reg[k][DIM_W-1]};
            if (rem_shift[k] >= {1'b0, cfg.dec})
                rem_next[k] = DEC_W'(rem_shift[k] - {1'b0, cfg.dec});
            else
                rem_next[k] = rem_shift[k][DEC_W-1:0];
        end
    end

    assign sync_last = (sync_step_reg == SSTEP_W'(DIM_W - 1));
    assign busy = (sync_state_reg != SYNC_DONE);

    // effective position of the pixel now on the port
    always_comb
    begin
        if (frame_start || (col_reg > cfg.width_m1))
        begin
            u = '0;
            u_ph = '0;
        end
        else
        begin
            u = col_reg;
            u_ph = col_ph_reg;
        end
        if (frame_start || (row_reg > cfg.height_m1))
        begin
            v = '0;
            v_ph = '0;
        end
        else
        begin
            v = row_reg;
            v_ph = row_ph_reg;
        end
    end

    always_comb
    begin
        pos.u = u;
        pos.v = v;
        pos.emit = (u_ph == '0) && (v_ph == '0);
        pos.last = (u == last_u_reg) && (v == last_v_reg);
    end

    always_comb
    begin
        col_next = u + DIM_W'(1);
        col_ph_next = (DEC_W'(u_ph + DEC_W'(1)) == cfg.dec) ? '0 : DEC_W'(u_ph + DEC_W'(1));
        row_next = v;
        row_ph_next = v_ph;
        if (u == cfg.width_m1)
        begin
            col_next = '0;
            col_ph_next = '0;
            if (v == cfg.height_m1)
            begin
                row_next = '0;
                row_ph_next = '0;
            end
            else
            begin
                row_next = v + DIM_W'(1);
                row_ph_next = (DEC_W'(v_ph + DEC_W'(1)) == cfg.dec) ? '0
                                                                    : DEC_W'(v_ph + DEC_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_state_reg <= SYNC_LOAD;
            sync_step_reg  <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            col_ph_reg     <= '0;
            row_ph_reg     <= '0;
            last_u_reg     <= '0;
            last_v_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
                sync_state_reg <= SYNC_LOAD;
            else
            begin
                case (sync_state_reg)
                    SYNC_LOAD:
                    begin
                        sync_step_reg  <= '0;
                        sync_state_reg <= SYNC_RUN;
                    end
                    SYNC_RUN:
                    begin
                        sync_step_reg <= SSTEP_W'(sync_step_reg + SSTEP_W'(1));
                        if (sync_last)
                        begin
                            sync_state_reg <= SYNC_DONE;
                            col_ph_reg <= rem_next[0];
                            row_ph_reg <= rem_next[1];
                            last_u_reg <= cfg.width_m1 - DIM_W'(rem_next[2]);
                            last_v_reg <= cfg.height_m1 - DIM_W'(rem_next[3]);
                        end
                    end
                    SYNC_DONE: ;
                    default: sync_state_reg <= SYNC_LOAD;
                endcase
            end
            if (pix_accept)
            begin
                col_reg    <= col_next;
                row_reg    <= row_next;
                col_ph_reg <= col_ph_next;
                row_ph_reg <= row_ph_next;
            end
        end
    end

    // remainder lanes: column, row, last column index, last row index
    always_ff @(posedge clk)
    begin
        if (sync_state_reg == SYNC_LOAD)
        begin
            div_reg[0] <= col_reg;
            div_reg[1] <= row_reg;
            div_reg[2] <= cfg.width_m1;
            div_reg[3] <= cfg.height_m1;
            for (int k = 0; k < LANES; k++)
                rem_reg[k] <= '0;
        end
        else if (sync_state_reg == SYNC_RUN)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                div_reg[k] <= {div_reg[k][DIM_W-2:0], 1'b0};
                rem_reg[k] <= rem_next[k];
            end
        end
    end

endmodule

// File: rtl/core/dtpc_datapath.sv
// operand capture, products, rounded division lanes and output payload
// depends on dtpc_pkg; driven by dtpc_ctrl commands
module dtpc_datapath
    import dtpc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  pix_pos_t           pos,
    input  logic [15:0]        depth_raw,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,
    output logic signed [31:0] x_mm,
    output logic signed [31:0] y_mm,
    output logic signed [31:0] z_mm,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               last_point
);

    localparam int LANES = 3;

    logic [15:0]        raw_reg;
    logic [DIM_W-1:0]   u_reg;
    logic [DIM_W-1:0]   v_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic               last_reg;
    logic signed [33:0] prod_x_reg;
    logic signed [33:0] prod_y_reg;
    logic [27:0]        prod_z_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [NUM_W-1:0]   num_reg [0:LANES-1];
    logic [DEN_W-1:0]   rem_reg [0:LANES-1];
    logic               neg_reg [0:LANES-1];
    logic [STEP_W-1:0]  step_reg;

    logic signed [16:0] du;
    logic signed [16:0] dv;
    logic signed [16:0] mult_a;
    logic signed [33:0] prod_x_next;
    logic signed [33:0] prod_y_next;
    logic [27:0]        prod_z_next;
    logic [17:0]        d_sel;
    logic [32:0]        mag [0:LANES-1];
    logic [DEN_W:0]     rem_shift [0:LANES-1];
    logic [DEN_W-1:0]   rem_next [0:LANES-1];
    logic               qbit [0:LANES-1];
    logic               missing;

    // round-half-away result clipped to 32 bits
    function automatic logic signed [31:0] sat32(input logic [NUM_W-1:0] q, input logic neg);
        logic signed [31:0] r;
        if (neg)
        begin
            if (q > NUM_W'(64'h8000_0000))
                r = 32'sh8000_0000;
            else
                r = 32'(-q[31:0]);
        end
        else
        begin
            if (q > NUM_W'(64'h7FFF_FFFF))
                r = 32'sh7FFF_FFFF;
            else
                r = q[31:0];
        end
        return r;
    endfunction

    always_comb
    begin
        du = $signed({1'b0, u_reg, 4'b0000}) - $signed({1'b0, cfg.cx});
        dv = $signed({1'b0, v_reg, 4'b0000}) - $signed({1'b0, cfg.cy});
        if (cfg.mode == MODE_DEPTH)
            mult_a = $signed({1'b0, raw_reg});
        else
            mult_a = $signed({7'b0, cfg.baseline});
        prod_x_next = mult_a * du;
        prod_y_next = mult_a * dv;
        prod_z_next = cfg.focal * cfg.baseline;
    end

    always_comb
    begin
        d_sel = (cfg.mode == MODE_DISPARITY) ? {2'b00, raw_reg} : cfg.focal;
        mag[0] = prod_x_reg[33] ? 33'(-prod_x_reg) : prod_x_reg[32:0];
        mag[1] = prod_y_reg[33] ? 33'(-prod_y_reg) : prod_y_reg[32:0];
        mag[2] = {5'b0, prod_z_reg};
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            rem_shift[k] = {rem_reg[k], num_reg[k][NUM_W-1]};
            qbit[k] = (rem_shift[k] >= {1'b0, den_reg});
            if (qbit[k])
                rem_next[k] = DEN_W'(rem_shift[k] - {1'b0, den_reg});
            else
                rem_next[k] = rem_shift[k][DEN_W-1:0];
        end
    end

    assign status.div_done = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign missing = (cfg.mode == MODE_DISPARITY) && (raw_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (cmd.prep_en)
            step_reg <= '0;
        else if (cmd.div_en)
            step_reg <= STEP_W'(step_reg + STEP_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg   <= depth_raw;
            u_reg     <= pos.u;
            v_reg     <= pos.v;
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            last_reg  <= pos.last;
        end
        if (cmd.mul_en)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
        end
        if (cmd.prep_en)
        begin
            den_reg <= {d_sel, 1'b0};
            for (int k = 0; k < LANES; k++)
            begin
                // 2*|n| + d, divided later by 2*d
                num_reg[k] <= {mag[k], 1'b0} + NUM_W'(d_sel);
                rem_reg[k] <= '0;
            end
            neg_reg[0] <= prod_x_reg[33];
            neg_reg[1] <= prod_y_reg[33];
            neg_reg[2] <= 1'b0;
        end
        else if (cmd.div_en)
        begin
            for (int k = 0; k < LANES; k++)
            begin
                num_reg[k] <= {num_reg[k][NUM_W-2:0], qbit[k]};
                rem_reg[k] <= rem_next[k];
            end
        end
        if (cmd.load_out)
        begin
            red_out    <= red_reg;
            green_out  <= green_reg;
            blue_out   <= blue_reg;
            last_point <= last_reg;
            if (missing)
            begin
                x_mm <= '0;
                y_mm <= '0;
                z_mm <= MISSING_Z;
            end
            else
            begin
                x_mm <= sat32(num_reg[0], neg_reg[0]);
                y_mm <= sat32(num_reg[1], neg_reg[1]);
                if (cfg.mode == MODE_DEPTH)
                    z_mm <= {16'b0, raw_reg};
                else
                    z_mm <= sat32(num_reg[2], neg_reg[2]);
            end
        end
    end

endmodule

// File: rtl/core/dtpc_ctrl.sv
// sequencer for one sampled pixel and output word handshake
// depends on dtpc_pkg
module dtpc_ctrl
    import dtpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_accept,
    input  logic       emit,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       out_valid
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_PREP, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign busy = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.capture  = (state_reg == S_IDLE) && pix_accept && emit;
        cmd.mul_en   = (state_reg == S_MUL);
        cmd.prep_en  = (state_reg == S_PREP);
        cmd.div_en   = (state_reg == S_DIV);
        cmd.load_out = (state_reg == S_OUT) && slot_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE: if (cmd.capture) state_reg <= S_MUL;
                S_MUL:  state_reg <= S_PREP;
                S_PREP: state_reg <= S_DIV;
                S_DIV:  if (status.div_done) state_reg <= S_OUT;
                S_OUT:  if (slot_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// File: rtl/core/depth_to_point_cloud.sv
// sampled pixel: capture, multiply, prep, 34 divider steps, load into the output word
// unsampled pixel: accepted while a sampled one is still in the divider
// a sampled pixel is captured only once the sequencer is idle again, so it waits out the 34-step radix-2 divider lanes
// reset and every register write start a remainder pass; input stalls meanwhile
// reset clears position, sequencer and output valid; registers load their defaults
module depth_to_point_cloud
    import dtpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input word
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [15:0]           depth_raw,
    input  logic [7:0]            red_in,
    input  logic [7:0]            green_in,
    input  logic [7:0]            blue_in,
    input  logic                  frame_start,
    // point output word
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic signed [31:0]    x_mm,
    output logic signed [31:0]    y_mm,
    output logic signed [31:0]    z_mm,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    output logic                  last_point
);

    `include "depth_to_point_cloud_defines.svh"

    cfg_t       cfg;
    logic       cfg_wr;
    pix_pos_t   pos;
    logic       pos_busy;
    logic       ctrl_busy;
    logic       pix_accept;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // sampled pixels wait while the sequencer holds an earlier point; all pixels wait during the phase rebuild
    assign in_stall = pos_busy || (pos.emit && ctrl_busy);
    assign pix_accept = in_valid && !in_stall;

    dtpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_wr    (cfg_wr),
        .cfg       (cfg)
    );

    // column/row counters and sampling phases
    dtpc_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cfg_wr      (cfg_wr),
        .frame_start (frame_start),
        .pix_accept  (pix_accept),
        .pos         (pos),
        .busy        (pos_busy)
    );

    dtpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_accept (pix_accept),
        .emit       (pos.emit),
        .out_stall  (out_stall),
        .status     (dp_status),
        .cmd        (dp_cmd),
        .busy       (ctrl_busy),
        .out_valid  (out_valid)
    );

    // products, rounding divides and the output register
    dtpc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (dp_cmd),
        .status     (dp_status),
        .pos        (pos),
        .depth_raw  (depth_raw),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .x_mm       (x_mm),
        .y_mm       (y_mm),
        .z_mm       (z_mm),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .last_point (last_point)
    );

    // a register write always triggers the phase rebuild
    `DTPC_ASSERT_NEXT(a_cfg_resync, clk, rst_n, cfg_valid && cfg_ready, in_stall)
    // the output word is never overwritten while still pending
    `DTPC_ASSERT_IMPL(a_load_slot_free, clk, rst_n, dp_cmd.load_out, !out_valid || !out_stall)
    // a sampled pixel is only captured by an idle sequencer with valid phases
    `DTPC_ASSERT_IMPL(a_capture_idle, clk, rst_n, dp_cmd.capture, !ctrl_busy && !pos_busy)

endmodule
